@@ hw/rtl/lct_pkg.sv @@
package lct_pkg;

  // address and cylinder sizes
  localparam int LBA_BITS = 32;
  localparam int CYL_BITS = 16;

  localparam logic [63:0] LBA_MAX = (64'd1 << LBA_BITS) - 64'd1;
  localparam logic [63:0] CYL_MAX = (64'd1 << CYL_BITS) - 64'd1;

  // stream packing
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 72;

  // operation codes (s_axis_tuser)
  localparam logic [1:0] OP_LBA2CHS = 2'd0;
  localparam logic [1:0] OP_CHS2LBA = 2'd1;
  localparam logic [1:0] OP_CHS2CHS = 2'd2;

  // status codes (m_axis_tuser)
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SRC_ERR = 2'd1;
  localparam logic [1:0] ST_CYL_OVF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_SPT = 2'd0;
  localparam logic [1:0] REG_SRC_HPC = 2'd1;
  localparam logic [1:0] REG_DST_SPT = 2'd2;
  localparam logic [1:0] REG_DST_HPC = 2'd3;

  // item moving through the divider cells
  typedef struct packed {
    logic                split;   // item still needs the target split
    logic [1:0]          status;
    logic [LBA_BITS-1:0] lba;
    logic [7:0]          side;    // remainder of the first division, in chain two
    logic [LBA_BITS-1:0] num;     // dividend bits shift out, quotient bits shift in
    logic [7:0]          rem;
    logic [8:0]          den;
  } lct_cell_t;

  // geometry register as used: zero counts as 1, above 256 as 256
  function automatic logic [8:0] geom(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > 9'd256) begin
      r = 9'd256;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/lct_front.sv @@
module lct_front import lct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_in,
  input  logic [1:0]          operation,
  input  logic [31:0]         lba_in,
  input  logic [15:0]         cylinder_in,
  input  logic [7:0]          head_in,
  input  logic [8:0]          sector_in,
  input  logic [8:0]          src_spt,
  input  logic [8:0]          src_hpc,
  input  logic [8:0]          dst_spt,
  output logic                vld_out,
  output lct_cell_t           q
);

  localparam int P1_W = 24;
  localparam int P2_W = P1_W + 9;

  // stage 0: range checks, cylinder * heads + head
  logic             vld0;
  logic [1:0]       op0;
  logic [31:0]      lba0;
  logic [8:0]       sec0;
  logic             chk0;
  logic [P1_W-1:0]  p1;
  logic             chk_next;
  logic [P1_W-1:0]  p1_next;

  assign chk_next = (sector_in != 9'd0) && (sector_in <= src_spt) &&
                    ({1'b0, head_in} < src_hpc) &&
                    (64'(cylinder_in) <= CYL_MAX);
  assign p1_next  = P1_W'(cylinder_in) * P1_W'(src_hpc) + P1_W'(head_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0  <= operation;
      lba0 <= lba_in;
      sec0 <= sector_in;
      chk0 <= chk_next;
      p1   <= p1_next;
    end
  end

  // stage 1: times sectors, plus sector - 1, then pick the lba
  logic [P2_W-1:0] l;
  logic            ok;
  lct_cell_t       q_next;

  assign l  = P2_W'(p1) * P2_W'(src_spt) + P2_W'(sec0) - P2_W'(1);
  assign ok = chk0 && (64'(l) <= LBA_MAX);

  always_comb begin
    q_next        = '0;
    q_next.den    = dst_spt;
    case (op0)
      OP_LBA2CHS: begin
        q_next.lba   = LBA_BITS'(lba0);
        q_next.split = 1'b1;
      end
      OP_CHS2LBA, OP_CHS2CHS: begin
        if (ok) begin
          q_next.lba   = LBA_BITS'(l);
          q_next.split = (op0 == OP_CHS2CHS);
        end else begin
          q_next.status = ST_SRC_ERR;
        end
      end
      default: begin
        q_next.lba = '0;
      end
    endcase
    q_next.num = q_next.lba;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ hw/rtl/lct_cell.sv @@
module lct_cell import lct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vld_in,
  input  lct_cell_t d,
  output logic      vld_out,
  output lct_cell_t q
);

  // one restoring division step
  logic [8:0] t;
  logic       ge;
  lct_cell_t  q_next;

  assign t  = {d.rem, d.num[LBA_BITS-1]};
  assign ge = (t >= d.den);

  always_comb begin
    q_next     = d;
    q_next.rem = ge ? 8'(t - d.den) : 8'(t);
    q_next.num = {d.num[LBA_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ hw/rtl/lct_chain.sv @@
module lct_chain import lct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vld_in,
  input  lct_cell_t d,
  output logic      vld_out,
  output lct_cell_t q
);

  logic      vld [0:LBA_BITS];
  lct_cell_t stg [0:LBA_BITS];

  assign vld[0] = vld_in;
  assign stg[0] = d;

  for (genvar i = 0; i < LBA_BITS; i++) begin : g_cell
    lct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (vld[i]),
      .d       (stg[i]),
      .vld_out (vld[i+1]),
      .q       (stg[i+1])
    );
  end

  assign vld_out = vld[LBA_BITS];
  assign q       = stg[LBA_BITS];

endmodule

@@ hw/rtl/disk_lba_chs_translator.sv @@
// Pipeline: front end, two rows of LBA_BITS one-bit division cells, output register.
// Throughput: one transfer per cycle unless a stalled result holds the pipe; every
//   stage is a register and one item enters each cycle it moves. The rows set the depth.
// Reset (rst, synchronous): empties the pipe and the output register, geometry
//   returns to 64 sectors per track and 16 heads on both sides.
module disk_lba_chs_translator import lct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] lba_in, [47:32] cylinder_in, [55:48] head_in, [64:56] sector_in
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]           s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] lba_out, [47:32] cylinder_out, [55:48] head_out, [64:56] sector_out
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]           m_axis_tuser,
  // geometry register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [8:0]           cfg_data
);

  // ---------------------------------------------------------------------------
  // Geometry registers. Raw values are kept; the clamped copy feeds the datapath.
  // ---------------------------------------------------------------------------
  logic [8:0] src_spt_reg, src_hpc_reg, dst_spt_reg, dst_hpc_reg;
  logic [8:0] src_spt, src_hpc, dst_spt, dst_hpc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_spt_reg <= 9'd64;
      src_hpc_reg <= 9'd16;
      dst_spt_reg <= 9'd64;
      dst_hpc_reg <= 9'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_SPT: src_spt_reg <= cfg_data;
        REG_SRC_HPC: src_hpc_reg <= cfg_data;
        REG_DST_SPT: dst_spt_reg <= cfg_data;
        REG_DST_HPC: dst_hpc_reg <= cfg_data;
        default:     src_spt_reg <= src_spt_reg;
      endcase
    end
  end

  assign src_spt = geom(src_spt_reg);
  assign src_hpc = geom(src_hpc_reg);
  assign dst_spt = geom(dst_spt_reg);
  assign dst_hpc = geom(dst_hpc_reg);

  // ---------------------------------------------------------------------------
  // Flow control. The pipe moves as one; it also moves while a result waits in
  // the output register, as long as the last cell holds a bubble.
  // ---------------------------------------------------------------------------
  logic      en;
  logic      out_load;
  logic      f_vld, c1_vld, c2_vld;
  lct_cell_t f_q, c1_q, c2_in, c2_q;

  assign en            = !c2_vld || !m_axis_tvalid || m_axis_tready;
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // front end: CHS -> LBA fold and operation select
  lct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vld_in      (s_axis_tvalid),
    .operation   (s_axis_tuser),
    .lba_in      (s_axis_tdata[31:0]),
    .cylinder_in (s_axis_tdata[47:32]),
    .head_in     (s_axis_tdata[55:48]),
    .sector_in   (s_axis_tdata[64:56]),
    .src_spt     (src_spt),
    .src_hpc     (src_hpc),
    .dst_spt     (dst_spt),
    .vld_out     (f_vld),
    .q           (f_q)
  );

  // first row: lba / sectors per track
  lct_chain u_chain_spt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (f_vld),
    .d       (f_q),
    .vld_out (c1_vld),
    .q       (c1_q)
  );

  // second row: track number / heads; sector remainder rides along in side
  always_comb begin
    c2_in      = c1_q;
    c2_in.side = c1_q.rem;
    c2_in.rem  = '0;
    c2_in.den  = dst_hpc;
  end

  lct_chain u_chain_hpc (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (c1_vld),
    .d       (c2_in),
    .vld_out (c2_vld),
    .q       (c2_q)
  );

  // ---------------------------------------------------------------------------
  // Result assembly and output register.
  // ---------------------------------------------------------------------------
  logic [15:0] cyl_next;
  logic [7:0]  head_next;
  logic [8:0]  sec_next;
  logic [1:0]  st_next;

  always_comb begin
    cyl_next  = '0;
    head_next = '0;
    sec_next  = '0;
    st_next   = c2_q.status;
    if (c2_q.split) begin
      if (64'(c2_q.num) > CYL_MAX) begin
        st_next = ST_CYL_OVF;
      end else begin
        cyl_next  = 16'(c2_q.num);
        head_next = c2_q.rem;
        sec_next  = 9'(c2_q.side) + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, sec_next, head_next, cyl_next, 32'(c2_q.lba)};
      m_axis_tuser <= st_next;
    end
  end

endmodule

@@ hw/rtl/lct_checker.sv @@
module lct_checker import lct_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]           m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // bad source CHS clears every result field
  a_src_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_SRC_ERR |-> m_axis_tdata == '0)
    else $error("source error with nonzero result");

  // cylinder overflow keeps lba, clears CHS
  a_cyl_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_CYL_OVF |-> m_axis_tdata[64:32] == '0)
    else $error("overflow with nonzero CHS");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind disk_lba_chs_translator lct_checker u_lct_checker (.*);

@@ test/tb_disk_lba_chs_translator.sv @@
module tb_disk_lba_chs_translator;
  timeunit 1ns;
  timeprecision 1ps;

  import lct_pkg::*;

  // Operation code with no meaning; the block must answer all zero with status ok.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int LIMIT       = 200000;  // cycles before the run is declared hung
  localparam int DRAIN_WAIT  = 80;      // margin beyond the pipe depth before the final check
  localparam int HOLD_CYCLES = 300;     // long result-side hold-off, fills the pipe
  localparam int N_PHASES    = 10;

  // One translated address, as carried on the result stream.
  typedef struct packed {
    logic [31:0] lba;
    logic [15:0] cyl;
    logic [7:0]  head;
    logic [8:0]  sec;
    logic [1:0]  status;
  } xlate_t;

  // One command on the input stream, with an optional hand-typed answer.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] lba;
    logic [15:0] cyl;
    logic [7:0]  head;
    logic [8:0]  sec;
    logic        typed;
    xlate_t      want;
  } cmd_row_t;

  localparam xlate_t NO_WANT = '0;

  // Directed commands, all under the reset geometry (64 sectors, 16 heads,
  // so 1024 sectors per cylinder on both sides). Rows with typed=1 carry an
  // answer readable at a glance; the others go through the predictor.
  cmd_row_t directed [0:22] = '{
    // LBA to CHS: first sector, track end, next head, next cylinder
    '{OP_LBA2CHS, 32'd0,    16'd0, 8'd0, 9'd0, 1'b1, '{32'd0,    16'd0, 8'd0, 9'd1,  ST_OK}},
    '{OP_LBA2CHS, 32'd63,   16'd0, 8'd0, 9'd0, 1'b1, '{32'd63,   16'd0, 8'd0, 9'd64, ST_OK}},
    '{OP_LBA2CHS, 32'd64,   16'd0, 8'd0, 9'd0, 1'b1, '{32'd64,   16'd0, 8'd1, 9'd1,  ST_OK}},
    '{OP_LBA2CHS, 32'd1024, 16'd0, 8'd0, 9'd0, 1'b1, '{32'd1024, 16'd1, 8'd0, 9'd1,  ST_OK}},
    // last address with cylinder 65535, then the first one that overflows
    '{OP_LBA2CHS, 32'h03FF_FFFF, 16'd0, 8'd0, 9'd0, 1'b1,
      '{32'h03FF_FFFF, 16'hFFFF, 8'd15, 9'd64, ST_OK}},
    '{OP_LBA2CHS, 32'h0400_0000, 16'd0, 8'd0, 9'd0, 1'b1,
      '{32'h0400_0000, 16'd0, 8'd0, 9'd0, ST_CYL_OVF}},
    '{OP_LBA2CHS, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1,
      '{32'hFFFF_FFFF, 16'd0, 8'd0, 9'd0, ST_CYL_OVF}},
    '{OP_LBA2CHS, 32'hAAAA_AAAA, 16'h5555, 8'h55, 9'h155, 1'b0, NO_WANT},
    '{OP_LBA2CHS, 32'h0001_2345, 16'd0, 8'd0, 9'd0, 1'b0, NO_WANT},
    // CHS to LBA: corners, then each way a source address can be invalid
    '{OP_CHS2LBA, 32'd0, 16'd0,    8'd0,  9'd1,  1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_OK}},
    '{OP_CHS2LBA, 32'hFFFF_FFFF, 16'hFFFF, 8'd15, 9'd64, 1'b1,
      '{32'h03FF_FFFF, 16'd0, 8'd0, 9'd0, ST_OK}},
    '{OP_CHS2LBA, 32'd0, 16'd5,    8'd3,   9'd0,   1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2LBA, 32'd0, 16'd5,    8'd3,   9'd65,  1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2LBA, 32'd0, 16'd5,    8'd16,  9'd1,   1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2LBA, 32'd0, 16'hFFFF, 8'hFF,  9'd256, 1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2LBA, 32'd0, 16'd0,    8'd0,   9'h1FF, 1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2LBA, 32'd0, 16'h5555, 8'd10,  9'd42,  1'b0, NO_WANT},
    // CHS to CHS: same geometry both sides, so corners come back unchanged
    '{OP_CHS2CHS, 32'd0, 16'd0,    8'd0,  9'd1,  1'b1, '{32'd0, 16'd0, 8'd0, 9'd1, ST_OK}},
    '{OP_CHS2CHS, 32'd0, 16'hFFFF, 8'd15, 9'd64, 1'b1,
      '{32'h03FF_FFFF, 16'hFFFF, 8'd15, 9'd64, ST_OK}},
    '{OP_CHS2CHS, 32'd0, 16'd7,    8'd2,  9'd0,  1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_SRC_ERR}},
    '{OP_CHS2CHS, 32'd0, 16'd1234, 8'd7,  9'd33, 1'b0, NO_WANT},
    // unused operation: everything zero, status ok
    '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1,
      '{32'd0, 16'd0, 8'd0, 9'd0, ST_OK}},
    '{OP_UNUSED, 32'd0, 16'd0, 8'd0, 9'd0, 1'b1, '{32'd0, 16'd0, 8'd0, 9'd0, ST_OK}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = OP_LBA2CHS;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = REG_SRC_SPT;
  logic [8:0]           cfg_data = '0;

  // Sideband that travels with the command being offered, so the transfer
  // monitor sees the typed answer of exactly the command that was taken.
  logic   row_typed = 1'b0;
  xlate_t row_want  = '0;

  // Geometry as the block should hold it, tracked from register transfers.
  logic [8:0] src_spt, src_hpc, dst_spt, dst_hpc;

  xlate_t pending_xlate [$];   // translations still owed by the block

  int  mismatches = 0;
  int  cycles = 0;
  int  rx_gap = 0;
  int  n_ok = 0, n_src_err = 0, n_cyl_ovf = 0;
  int  n_cmds = 0;
  logic burst = 1'b0;    // both sides run with no idle cycles while set
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;

  disk_lba_chs_translator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Geometry register as the translation uses it: 0 acts as 1, >256 as 256.
  function automatic longint unsigned used_geom(input logic [8:0] v);
    if (v == 9'd0) begin
      return 64'd1;
    end else if (v > 9'd256) begin
      return 64'd256;
    end
    return 64'(v);
  endfunction

  // Expected answer for one command under the tracked geometry.
  function automatic xlate_t translate(input logic [1:0] op, input logic [31:0] lba,
                                       input logic [15:0] cyl, input logic [7:0] head,
                                       input logic [8:0] sec);
    xlate_t            r;
    longint unsigned   spt, hpc, addr, c;
    logic              split;
    r = '0;
    split = 1'b0;
    addr = 64'd0;
    case (op)
      OP_LBA2CHS: begin
        addr = 64'(lba);
        split = 1'b1;
      end
      OP_CHS2LBA, OP_CHS2CHS: begin
        spt = used_geom(src_spt);
        hpc = used_geom(src_hpc);
        // cylinder is 16 bits wide, so it never exceeds the cylinder limit here
        if (sec != 9'd0 && 64'(sec) <= spt && 64'(head) < hpc) begin
          addr = (64'(cyl) * hpc + 64'(head)) * spt + 64'(sec) - 64'd1;
        end else begin
          addr = LBA_MAX + 64'd1;
        end
        if (addr > LBA_MAX) begin
          r.status = ST_SRC_ERR;
        end else begin
          r.lba = addr[31:0];
          split = (op == OP_CHS2CHS);
        end
      end
      default: ;
    endcase
    if (split) begin
      spt = used_geom(dst_spt);
      hpc = used_geom(dst_hpc);
      c = addr / (spt * hpc);
      r.lba = addr[31:0];
      if (c > CYL_MAX) begin
        r.status = ST_CYL_OVF;
      end else begin
        r.cyl  = c[15:0];
        r.head = 8'((addr / spt) % hpc);
        r.sec  = 9'(addr % spt + 64'd1);
      end
    end
    return r;
  endfunction

  function automatic bit field_diff(input string name, input longint unsigned want,
                                    input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Transfer monitor: tracks register writes and queues one expected
  // translation per accepted command.
  always @(posedge clk) begin
    if (rst) begin
      src_spt <= 9'd64;
      src_hpc <= 9'd16;
      dst_spt <= 9'd64;
      dst_hpc <= 9'd16;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_SPT: src_spt <= cfg_data;
          REG_SRC_HPC: src_hpc <= cfg_data;
          REG_DST_SPT: dst_spt <= cfg_data;
          REG_DST_HPC: dst_hpc <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (row_typed) begin
          pending_xlate.push_back(row_want);
        end else begin
          pending_xlate.push_back(translate(s_axis_tuser, s_axis_tdata[31:0],
                                            s_axis_tdata[47:32], s_axis_tdata[55:48],
                                            s_axis_tdata[64:56]));
        end
      end
    end
  end

  // Result side: checks each transfer against the oldest expectation, then
  // draws how long to stall before taking the next one.
  always @(posedge clk) begin : result_side
    xlate_t got;
    xlate_t want;
    int     nxt;
    bit     bad;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      nxt = (rx_gap > 0) ? rx_gap - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[55:48],
                m_axis_tdata[64:56], m_axis_tuser};
        case (got.status)
          ST_OK:      n_ok++;
          ST_SRC_ERR: n_src_err++;
          default:    n_cyl_ovf++;
        endcase
        if (pending_xlate.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = pending_xlate.pop_front();
          bad = field_diff("lba_out", want.lba, got.lba)
              | field_diff("cylinder_out", want.cyl, got.cyl)
              | field_diff("head_out", want.head, got.head)
              | field_diff("sector_out", want.sec, got.sec)
              | field_diff("status", want.status, got.status);
          if (bad) begin
            mismatches++;
          end
        end
        nxt = burst ? 0 : $urandom_range(0, 14);
      end
      rx_gap <= nxt;
      m_axis_tready <= (nxt == 0) && !rx_hold;
    end
  end

  // Long hold-off on the result side; the command side keeps pushing meanwhile.
  initial begin : hold_off
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t ns: no progress after %0d cycles", $time, LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one command. Valid is lowered only when an idle gap follows, so a
  // back-to-back command never sees valid dropped and raised in one step.
  task automatic send_cmd(input cmd_row_t r);
    int gap;
    gap = (burst || rx_hold) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {{(S_TDATA_W-65){1'b0}}, r.sec, r.head, r.cyl, r.lba};
    row_typed     <= r.typed;
    row_want      <= r.want;
    do @(posedge clk); while (!s_axis_tready);
    n_cmds++;
  endtask

  // Stop offering and wait until every owed translation has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_xlate.size() != 0) @(posedge clk);
  endtask

  // Write all four geometry registers, valid held high across the writes.
  task automatic load_geometry(input logic [8:0] g [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= g[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random command. Most source addresses fit the source geometry so the
  // target split is reached; LBAs cluster around the cylinder limit too.
  function automatic cmd_row_t random_cmd(input logic [8:0] g [4]);
    cmd_row_t        r;
    longint unsigned sp, hp, lim;
    int unsigned     pick;
    r = '0;
    pick = $urandom_range(0, 15);
    r.op = (pick == 0) ? OP_UNUSED : (pick < 6) ? OP_LBA2CHS :
           (pick < 11) ? OP_CHS2LBA : OP_CHS2CHS;
    lim = used_geom(g[REG_DST_SPT]) * used_geom(g[REG_DST_HPC]) * 64'd65536;
    case ($urandom_range(0, 3))
      0: r.lba = $urandom_range(0, 100000);
      1: r.lba = (lim + 8 > 64'h1_0000_0000) ? $urandom : 32'(lim - 8 + $urandom_range(0, 15));
      default: r.lba = $urandom;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      sp = used_geom(g[REG_SRC_SPT]);
      hp = used_geom(g[REG_SRC_HPC]);
      r.cyl  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
      r.head = 8'($urandom_range(0, int'(hp) - 1));
      r.sec  = 9'($urandom_range(1, int'(sp)));
    end else begin
      r.cyl  = 16'($urandom);
      r.head = 8'($urandom);
      r.sec  = 9'($urandom);
    end
    return r;
  endfunction

  // Stimulus: reset, directed table under reset geometry, then phases of random
  // commands, each under its own geometry written while the block is idle.
  initial begin : stimulus
    logic [8:0] geo_sets [N_PHASES][4];
    int         n_items;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_cmd(directed[i]);
    end
    drain();

    // extremes first: all-ones, all-max, zero and out-of-range values,
    // large source into tiny target, tiny source into large target
    geo_sets[0] = '{9'd1,   9'd1,   9'd1,   9'd1};
    geo_sets[1] = '{9'd256, 9'd256, 9'd256, 9'd256};
    geo_sets[2] = '{9'd0,   9'd0,   9'h1FF, 9'd300};
    geo_sets[3] = '{9'd256, 9'd256, 9'd1,   9'd1};
    geo_sets[4] = '{9'd1,   9'd1,   9'd256, 9'd256};
    for (int p = 5; p < N_PHASES; p++) begin
      for (int i = 0; i < 4; i++) begin
        geo_sets[p][i] = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(1, 256));
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      load_geometry(geo_sets[p]);
      // the hold-off phase gets more commands so the pipe fills and stalls
      n_items = (p == 1) ? 150 : 40;
      if (p == 1) begin
        hold_req = 1'b1;
      end
      for (int k = 0; k < n_items; k++) begin
        if (k % 20 == 0) begin
          burst = ($urandom_range(0, 3) == 0);
        end
        send_cmd(random_cmd(geo_sets[p]));
      end
      burst = 1'b0;
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_xlate.size() != 0) begin
      $display("%0t ns: %0d translations never arrived", $time, pending_xlate.size());
      mismatches++;
    end

    $display("%0d commands translated over reset geometry and %0d register settings",
             n_cmds, N_PHASES);
    $display("results: %0d ok, %0d source errors, %0d cylinder overflows, %0d mismatches",
             n_ok, n_src_err, n_cyl_ovf, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
